FILE: rtl/core/layer_zorder_stack_core_macros.svh
// assertion macros used by the layer z-order stack core
`ifndef LAYER_ZORDER_STACK_CORE_MACROS_SVH
`define LAYER_ZORDER_STACK_CORE_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define LZS_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk outside reset
`define LZS_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/lzs_pkg.sv
// types and constants of the layer z-order stack
`timescale 1ns / 1ps
package lzs_pkg;

  localparam int OP_W     = 2;
  localparam int LAYER_W  = 6;
  localparam int REQ_W    = 8;
  localparam int HEIGHT_W = 7;
  localparam int RANGE_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_SET   = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

FILE: rtl/core/lzs_in_if.sv
// command word channel of the layer z-order stack
`timescale 1ns / 1ps
interface lzs_in_if;
  logic                                     valid;
  logic                                     ready;
  lzs_pkg::op_t                             operation;
  logic [lzs_pkg::LAYER_W-1:0]              layer;
  logic signed [lzs_pkg::REQ_W-1:0]         requested_height;

  modport source (output valid, output operation, output layer, output requested_height,
                  input ready);
  modport sink (input valid, input operation, input layer, input requested_height,
                output ready);
endinterface

FILE: rtl/core/lzs_out_if.sv
// result word channel of the layer z-order stack
`timescale 1ns / 1ps
interface lzs_out_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     status;
  logic [lzs_pkg::LAYER_W-1:0]              layer_out;
  logic signed [lzs_pkg::HEIGHT_W-1:0]      new_height;
  logic signed [lzs_pkg::HEIGHT_W-1:0]      top_height;
  logic                                     refresh_needed;
  logic [lzs_pkg::RANGE_W-1:0]              map_from;
  logic [lzs_pkg::RANGE_W-1:0]              draw_from;
  logic signed [lzs_pkg::RANGE_W-1:0]       draw_to;

  modport source (output valid, output status, output layer_out, output new_height,
                  output top_height, output refresh_needed, output map_from,
                  output draw_from, output draw_to, input ready);
  modport sink (input valid, input status, input layer_out, input new_height,
                input top_height, input refresh_needed, input map_from,
                input draw_from, input draw_to, output ready);
endinterface

FILE: rtl/core/lzs_ram.sv
// generic simple dual-port ram, one write and one registered read port
`timescale 1ns / 1ps
module lzs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/layer_zorder_stack_core.sv
// layer z-order stack: top level with sequencer and two state rams
// channels: in_ch takes one command word (allocate, set height, free, no-op),
//   out_ch returns one result word per command, both valid/ready handshaked
// sequence from the accepting edge to out_ch.valid: allocate reads the info ram,
//   one entry per cycle, until it finds a free layer or reports full at the last;
//   set height and free look the layer up, shift the n layers in between in the
//   order ram (at most LAYERS-1), then place the layer if it takes a new visible
//   height; no-op, set height on an unused layer and a layer out of range go
//   straight to the result
// throughput: one command at a time; the order ram walk moves one height per
//   cycle, and no new command is taken until the result is loaded
// reset: rst_n low for one clock empties the stack: no layer in use, all
//   heights hidden, top at -1; no clearing pass, the info ram is masked by
//   per-entry written flags
// stall: a finished result waits in the output register while out_ch.ready is
//   low; the next command is still taken and runs until its own result is due
`timescale 1ns / 1ps
`include "layer_zorder_stack_core_macros.svh"
module layer_zorder_stack_core #(
  parameter int LAYERS = 64
) (
  input logic          clk,
  input logic          rst_n,
  lzs_in_if.sink       in_ch,
  lzs_out_if.source    out_ch
);

  // layer index, count and signed height widths
  localparam int LW  = $clog2(LAYERS);
  localparam int CNW = $clog2(LAYERS + 1);
  localparam int HW  = CNW + 1;
  localparam int CW  = ((HW > lzs_pkg::REQ_W) ? HW : lzs_pkg::REQ_W) + 1;
  localparam int IW  = HW + 1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ALLOC = 7'b0000010,
    ST_LOOK  = 7'b0000100,
    ST_SETUP = 7'b0001000,
    ST_SHIFT = 7'b0010000,
    ST_PLACE = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  state_t                         state_r, state_nxt;

  // command being worked on
  lzs_pkg::op_t                   op_r, op_nxt;
  logic [LW-1:0]                  lay_r, lay_nxt;
  logic signed [lzs_pkg::REQ_W-1:0] want_r, want_nxt;

  // stack state kept in flops
  logic signed [HW-1:0]           top_r, top_nxt;
  logic [LAYERS-1:0]              valid_r, valid_nxt;

  // info ram read tracking and move parameters
  logic [LW-1:0]                  info_ra_r, info_ra_nxt;
  logic signed [HW-1:0]           old_r, old_nxt;
  logic signed [HW-1:0]           nh_r, nh_nxt;
  logic                           use_new_r, use_new_nxt;
  logic [LW-1:0]                  dst_r, dst_nxt;
  logic [LW-1:0]                  wdst_r, wdst_nxt;
  logic [CNW-1:0]                 rem_r, rem_nxt;
  logic                           down_r, down_nxt;
  logic                           place_r, place_nxt;
  logic                           pend_r, pend_nxt;

  // result fields
  logic                           res_status_r, res_status_nxt;
  logic [lzs_pkg::LAYER_W-1:0]    res_layer_r, res_layer_nxt;
  logic signed [HW-1:0]           res_nh_r, res_nh_nxt;
  logic                           rf_need_r, rf_need_nxt;
  logic signed [HW-1:0]           rf_map_r, rf_map_nxt;
  logic signed [HW-1:0]           rf_dfrom_r, rf_dfrom_nxt;
  logic signed [HW-1:0]           rf_dto_r, rf_dto_nxt;

  // output register
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_load;
  logic                           out_status_r;
  logic [lzs_pkg::LAYER_W-1:0]    out_layer_r;
  logic signed [lzs_pkg::HEIGHT_W-1:0] out_nh_r;
  logic signed [lzs_pkg::HEIGHT_W-1:0] out_top_r;
  logic                           out_refresh_r;
  logic [lzs_pkg::RANGE_W-1:0]    out_map_r;
  logic [lzs_pkg::RANGE_W-1:0]    out_dfrom_r;
  logic signed [lzs_pkg::RANGE_W-1:0] out_dto_r;

  // info ram: {in use, height} per layer
  logic                           info_we;
  logic [LW-1:0]                  info_waddr;
  logic [IW-1:0]                  info_wdata;
  logic [LW-1:0]                  info_raddr;
  logic [IW-1:0]                  info_rd;

  // order ram: layer at each visible height
  logic                           order_we;
  logic [LW-1:0]                  order_waddr;
  logic [LW-1:0]                  order_wdata;
  logic [LW-1:0]                  order_raddr;
  logic [LW-1:0]                  order_rd;

  logic                           in_accept;
  logic                           lay_ok;
  logic                           info_use;
  logic signed [HW-1:0]           info_h;
  logic signed [HW-1:0]           top_p1;
  logic signed [CW-1:0]           want_w, lim_w, clamp_w;
  logic                           mv_down, mv_up;

  lzs_ram #(.WIDTH(IW), .DEPTH(LAYERS)) u_info_ram (
    .clk     (clk),
    .we      (info_we),
    .waddr   (info_waddr),
    .wdata   (info_wdata),
    .raddr   (info_raddr),
    .rd_data (info_rd)
  );

  lzs_ram #(.WIDTH(LW), .DEPTH(LAYERS)) u_order_ram (
    .clk     (clk),
    .we      (order_we),
    .waddr   (order_waddr),
    .wdata   (order_wdata),
    .raddr   (order_raddr),
    .rd_data (order_rd)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign lay_ok      = (int'(in_ch.layer) < LAYERS);

  // entries never written read as a free, hidden layer
  assign info_use = valid_r[info_ra_r] & info_rd[IW-1];
  assign info_h   = valid_r[info_ra_r] ? $signed(info_rd[HW-1:0]) : HW'(-1);
  assign top_p1   = top_r + HW'(1);

  // height clamp: -1 .. top for a visible layer, -1 .. top+1 for a hidden one
  always_comb begin
    want_w = CW'(want_r);
    lim_w  = (info_h >= 0) ? CW'(top_r) : CW'(top_p1);
    clamp_w = (want_w > lim_w) ? lim_w : want_w;
    if (clamp_w < CW'(-1)) begin
      clamp_w = CW'(-1);
    end
  end

  assign mv_down = (old_r > nh_r);
  assign mv_up   = (nh_r > old_r);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    lay_nxt        = lay_r;
    want_nxt       = want_r;
    top_nxt        = top_r;
    valid_nxt      = valid_r;
    info_ra_nxt    = info_ra_r;
    old_nxt        = old_r;
    nh_nxt         = nh_r;
    use_new_nxt    = use_new_r;
    dst_nxt        = dst_r;
    wdst_nxt       = wdst_r;
    rem_nxt        = rem_r;
    down_nxt       = down_r;
    place_nxt      = place_r;
    pend_nxt       = pend_r;
    res_status_nxt = res_status_r;
    res_layer_nxt  = res_layer_r;
    res_nh_nxt     = res_nh_r;
    rf_need_nxt    = rf_need_r;
    rf_map_nxt     = rf_map_r;
    rf_dfrom_nxt   = rf_dfrom_r;
    rf_dto_nxt     = rf_dto_r;
    out_load       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;

    info_we     = 1'b0;
    info_waddr  = lay_r;
    info_wdata  = {1'b0, HW'(-1)};
    info_raddr  = info_ra_r;
    order_we    = 1'b0;
    order_waddr = wdst_r;
    order_wdata = order_rd;
    order_raddr = dst_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          op_nxt         = in_ch.operation;
          lay_nxt        = LW'(in_ch.layer);
          want_nxt       = in_ch.requested_height;
          res_status_nxt = lzs_pkg::STATUS_DONE;
          res_layer_nxt  = in_ch.layer;
          res_nh_nxt     = HW'(-1);
          rf_need_nxt    = 1'b0;
          rf_map_nxt     = '0;
          rf_dfrom_nxt   = '0;
          rf_dto_nxt     = HW'(-1);
          if (in_ch.operation == lzs_pkg::OP_ALLOC) begin
            info_raddr  = '0;
            info_ra_nxt = '0;
            state_nxt   = ST_ALLOC;
          end else if (lay_ok) begin
            info_raddr  = LW'(in_ch.layer);
            info_ra_nxt = LW'(in_ch.layer);
            state_nxt   = ST_LOOK;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_ALLOC: begin
        // data of info_ra_r is here; next entry is fetched meanwhile
        if (!info_use) begin
          info_we       = 1'b1;
          info_waddr    = info_ra_r;
          info_wdata    = {1'b1, HW'(-1)};
          res_layer_nxt = lzs_pkg::LAYER_W'(info_ra_r);
          state_nxt     = ST_FIN;
        end else if (info_ra_r == LW'(LAYERS - 1)) begin
          res_status_nxt = lzs_pkg::STATUS_FULL;
          res_layer_nxt  = '0;
          state_nxt      = ST_FIN;
        end else begin
          info_raddr  = info_ra_r + LW'(1);
          info_ra_nxt = info_ra_r + LW'(1);
        end
      end
      ST_LOOK: begin
        old_nxt = info_h;
        if (op_r == lzs_pkg::OP_SET && info_use) begin
          nh_nxt      = HW'(clamp_w);
          use_new_nxt = 1'b1;
          state_nxt   = ST_SETUP;
        end else if (op_r == lzs_pkg::OP_FREE) begin
          nh_nxt      = HW'(-1);
          use_new_nxt = 1'b0;
          state_nxt   = ST_SETUP;
        end else begin
          res_nh_nxt = info_h;
          state_nxt  = ST_FIN;
        end
      end
      ST_SETUP: begin
        info_we    = 1'b1;
        info_waddr = lay_r;
        info_wdata = {use_new_r, nh_r};
        res_nh_nxt = nh_r;
        pend_nxt   = 1'b0;
        place_nxt  = 1'b1;
        if (mv_down && nh_r >= 0) begin
          // lowered: layers in between move up one place
          dst_nxt      = LW'(old_r);
          down_nxt     = 1'b1;
          rem_nxt      = CNW'(old_r - nh_r);
          rf_map_nxt   = nh_r + HW'(1);
          rf_dfrom_nxt = nh_r + HW'(1);
          rf_dto_nxt   = old_r;
        end else if (mv_down) begin
          // hidden: layers above close the gap
          dst_nxt      = LW'(old_r);
          down_nxt     = 1'b0;
          rem_nxt      = CNW'(top_r - old_r);
          place_nxt    = 1'b0;
          top_nxt      = top_r - HW'(1);
          rf_map_nxt   = '0;
          rf_dfrom_nxt = '0;
          rf_dto_nxt   = old_r - HW'(1);
        end else if (old_r >= 0) begin
          // raised: layers in between move down one place
          dst_nxt      = LW'(old_r);
          down_nxt     = 1'b0;
          rem_nxt      = CNW'(nh_r - old_r);
          rf_map_nxt   = nh_r;
          rf_dfrom_nxt = nh_r;
          rf_dto_nxt   = nh_r;
        end else begin
          // inserted: layers from nh up move up one place
          dst_nxt      = LW'(top_p1);
          down_nxt     = 1'b1;
          rem_nxt      = CNW'(top_p1 - nh_r);
          top_nxt      = top_p1;
          rf_map_nxt   = nh_r;
          rf_dfrom_nxt = nh_r;
          rf_dto_nxt   = nh_r;
        end
        if (mv_down || mv_up) begin
          rf_need_nxt = 1'b1;
          if (rem_nxt != '0) begin
            state_nxt = ST_SHIFT;
          end else if (place_nxt) begin
            state_nxt = ST_PLACE;
          end else begin
            state_nxt = ST_FIN;
          end
        end else begin
          rf_map_nxt   = '0;
          rf_dfrom_nxt = '0;
          rf_dto_nxt   = HW'(-1);
          top_nxt      = top_r;
          state_nxt    = ST_FIN;
        end
      end
      ST_SHIFT: begin
        // read order[src]; in the cycle after, write it at dst and renumber that layer
        if (rem_r != '0) begin
          order_raddr = down_r ? (dst_r - LW'(1)) : (dst_r + LW'(1));
          wdst_nxt    = dst_r;
          dst_nxt     = down_r ? (dst_r - LW'(1)) : (dst_r + LW'(1));
          rem_nxt     = rem_r - CNW'(1);
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          order_we    = 1'b1;
          order_waddr = wdst_r;
          order_wdata = order_rd;
          info_we     = 1'b1;
          info_waddr  = order_rd;
          info_wdata  = {1'b1, {(HW - LW){1'b0}}, wdst_r};
        end
        if (rem_r == '0) begin
          state_nxt = place_r ? ST_PLACE : ST_FIN;
        end
      end
      ST_PLACE: begin
        order_we    = 1'b1;
        order_waddr = LW'(nh_r);
        order_wdata = lay_r;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (info_we) begin
      valid_nxt[info_waddr] = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      top_r       <= HW'(-1);
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      rem_r       <= rem_nxt;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    lay_r        <= lay_nxt;
    want_r       <= want_nxt;
    info_ra_r    <= info_ra_nxt;
    old_r        <= old_nxt;
    nh_r         <= nh_nxt;
    use_new_r    <= use_new_nxt;
    dst_r        <= dst_nxt;
    wdst_r       <= wdst_nxt;
    down_r       <= down_nxt;
    place_r      <= place_nxt;
    res_status_r <= res_status_nxt;
    res_layer_r  <= res_layer_nxt;
    res_nh_r     <= res_nh_nxt;
    rf_need_r    <= rf_need_nxt;
    rf_map_r     <= rf_map_nxt;
    rf_dfrom_r   <= rf_dfrom_nxt;
    rf_dto_r     <= rf_dto_nxt;
  end

  // result word register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r  <= res_status_r;
      out_layer_r   <= res_layer_r;
      out_nh_r      <= lzs_pkg::HEIGHT_W'(res_nh_r);
      out_top_r     <= lzs_pkg::HEIGHT_W'(top_r);
      out_refresh_r <= rf_need_r;
      out_map_r     <= lzs_pkg::RANGE_W'(rf_map_r);
      out_dfrom_r   <= lzs_pkg::RANGE_W'(rf_dfrom_r);
      out_dto_r     <= lzs_pkg::RANGE_W'(rf_dto_r);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.layer_out      = out_layer_r;
  assign out_ch.new_height     = out_nh_r;
  assign out_ch.top_height     = out_top_r;
  assign out_ch.refresh_needed = out_refresh_r;
  assign out_ch.map_from       = out_map_r;
  assign out_ch.draw_from      = out_dfrom_r;
  assign out_ch.draw_to        = out_dto_r;

  // top stays within the stack
  `LZS_CHECK_NOW(a_top_range, 1'b1, (top_r >= -1) && (top_r < LAYERS), "top out of range")
  // a taken command always starts work
  `LZS_CHECK_NEXT(a_busy_after_accept, in_accept, state_r != ST_IDLE, "idle after accept")
  // order ram is only written inside the visible stack
  `LZS_CHECK_NOW(a_order_in_stack, order_we, $signed({1'b0, order_waddr}) <= top_r,
                 "order write above top")

endmodule
